@@ rtl/core/gbs_pkg.sv @@
// Shared constants and types of the greedy box suppression block.
`default_nettype none
package gbs_pkg;
	localparam int MAX_BOXES = 64;
	localparam int IDX_W = $clog2(MAX_BOXES);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int MUL_W = 17;
	localparam int PROD_W = 2 * MUL_W;
	localparam int BOX_W = 90;
	localparam int TDATA_W = 96;

	localparam logic CFG_IOU_LIMIT = 1'b0;
	localparam logic CFG_KEEP_LIMIT = 1'b1;

	localparam logic [15:0] IOU_LIMIT_RESET = 16'd29491;
	localparam logic [6:0] KEEP_LIMIT_RESET = 7'd64;

	typedef struct packed {
		logic [9:0] cls;
		logic [15:0] score;
		logic [15:0] bottom;
		logic [15:0] right;
		logic [15:0] top;
		logic [15:0] left;
	} box_t;

	typedef struct packed {
		logic start;
		box_t a;
		box_t b;
	} iou_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} iou_rsp_t;
endpackage
`default_nettype wire

@@ rtl/core/gbs_box_mem.sv @@
// Box store memory with one write port and one registered read port.
`default_nettype none
module gbs_box_mem (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [gbs_pkg::IDX_W-1:0] wr_addr,
	input wire gbs_pkg::box_t wr_data,
	input wire logic [gbs_pkg::IDX_W-1:0] rd_addr,
	output gbs_pkg::box_t rd_data
);
	import gbs_pkg::*;

	box_t mem [MAX_BOXES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

@@ rtl/core/gbs_mul.sv @@
// Shared unsigned multiplier with a registered product.
`default_nettype none
module gbs_mul (
	input wire logic clk,
	input wire logic [gbs_pkg::MUL_W-1:0] op_a,
	input wire logic [gbs_pkg::MUL_W-1:0] op_b,
	output logic [gbs_pkg::PROD_W-1:0] prod_q
);
	import gbs_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end
endmodule
`default_nettype wire

@@ rtl/core/gbs_iou.sv @@
// Overlap test of two boxes, sequenced over one shared multiplier.
`default_nettype none
module gbs_iou (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [15:0] iou_limit,
	input wire gbs_pkg::iou_req_t req,
	output gbs_pkg::iou_rsp_t rsp_q
);
	import gbs_pkg::*;

	localparam logic [3:0] U_IDLE = 4'd0;
	localparam logic [3:0] U_CHK = 4'd1;
	localparam logic [3:0] U_AA = 4'd2;
	localparam logic [3:0] U_AB = 4'd3;
	localparam logic [3:0] U_UNI = 4'd4;
	localparam logic [3:0] U_DEC = 4'd5;
	localparam logic [3:0] U_PL = 4'd6;
	localparam logic [3:0] U_PH = 4'd7;
	localparam logic [3:0] U_CMP = 4'd8;

	logic [3:0] state_q;
	box_t a_q;
	box_t b_q;
	logic [PROD_W-1:0] inter_q;
	logic [PROD_W-1:0] aa_q;
	logic signed [PROD_W:0] uni_q;
	logic [PROD_W-1:0] plo_q;
	logic [PROD_W-1:0] phi_q;
	logic [MUL_W-1:0] op_a;
	logic [MUL_W-1:0] op_b;
	logic [PROD_W-1:0] prod;
	logic [15:0] l, t, r, btm, wa, ha, wb, hb;
	logic signed [17:0] iw;
	logic signed [17:0] ih;
	logic [50:0] lhs;
	logic [50:0] rhs;

	gbs_mul u_mul (
		.clk(clk),
		.op_a(op_a),
		.op_b(op_b),
		.prod_q(prod)
	);

	always_comb begin
		l = (a_q.left > b_q.left) ? a_q.left : b_q.left;
		t = (a_q.top > b_q.top) ? a_q.top : b_q.top;
		r = (a_q.right < b_q.right) ? a_q.right : b_q.right;
		btm = (a_q.bottom < b_q.bottom) ? a_q.bottom : b_q.bottom;
		iw = $signed({2'b00, r}) - $signed({2'b00, l}) + 18'sd16;
		ih = $signed({2'b00, btm}) - $signed({2'b00, t}) + 18'sd16;
		wa = (a_q.right > a_q.left) ? 16'(a_q.right - a_q.left) : 16'd0;
		ha = (a_q.bottom > a_q.top) ? 16'(a_q.bottom - a_q.top) : 16'd0;
		wb = (b_q.right > b_q.left) ? 16'(b_q.right - b_q.left) : 16'd0;
		hb = (b_q.bottom > b_q.top) ? 16'(b_q.bottom - b_q.top) : 16'd0;
		lhs = {2'b00, inter_q[32:0], 16'd0};
		rhs = {phi_q[33:0], 17'd0} + {17'd0, plo_q};
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			U_CHK: begin
				op_a = iw[MUL_W-1:0];
				op_b = ih[MUL_W-1:0];
			end
			U_AA: begin
				op_a = {1'b0, wa};
				op_b = {1'b0, ha};
			end
			U_AB: begin
				op_a = {1'b0, wb};
				op_b = {1'b0, hb};
			end
			U_DEC: begin
				op_a = {1'b0, iou_limit};
				op_b = uni_q[MUL_W-1:0];
			end
			U_PL: begin
				op_a = {1'b0, iou_limit};
				op_b = uni_q[2*MUL_W-1:MUL_W];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == U_IDLE && req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		if (state_q == U_AA) begin
			inter_q <= prod;
		end
		if (state_q == U_AB) begin
			aa_q <= prod;
		end
		if (state_q == U_UNI) begin
			uni_q <= $signed({1'b0, aa_q}) + $signed({1'b0, prod}) - $signed({1'b0, inter_q});
		end
		if (state_q == U_PL) begin
			plo_q <= prod;
		end
		if (state_q == U_PH) begin
			phi_q <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			rsp_q <= '0;
		end else begin
			case (state_q)
				U_IDLE: begin
					rsp_q.done <= 1'b0;
					if (req.start) begin
						state_q <= U_CHK;
					end
				end
				U_CHK: begin
					if (iw <= 18'sd0 || ih <= 18'sd0) begin
						rsp_q.done <= 1'b1;
						rsp_q.hit <= 1'b0;
						state_q <= U_IDLE;
					end else begin
						rsp_q.done <= 1'b0;
						state_q <= U_AA;
					end
				end
				U_AA: begin
					rsp_q.done <= 1'b0;
					state_q <= U_AB;
				end
				U_AB: begin
					rsp_q.done <= 1'b0;
					state_q <= U_UNI;
				end
				U_UNI: begin
					rsp_q.done <= 1'b0;
					state_q <= U_DEC;
				end
				U_DEC: begin
					if (uni_q == '0) begin
						rsp_q.done <= 1'b1;
						rsp_q.hit <= 1'b1;
						state_q <= U_IDLE;
					end else if (uni_q < 0) begin
						rsp_q.done <= 1'b1;
						rsp_q.hit <= 1'b0;
						state_q <= U_IDLE;
					end else begin
						rsp_q.done <= 1'b0;
						state_q <= U_PL;
					end
				end
				U_PL: begin
					rsp_q.done <= 1'b0;
					state_q <= U_PH;
				end
				U_PH: begin
					rsp_q.done <= 1'b0;
					state_q <= U_CMP;
				end
				U_CMP: begin
					rsp_q.done <= 1'b1;
					rsp_q.hit <= (lhs > rhs);
					state_q <= U_IDLE;
				end
				default: begin
					rsp_q.done <= 1'b0;
					state_q <= U_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/greedy_box_suppression_top.sv @@
// Top level of the greedy box suppression block: ordering, sequencing and output register.
// A box is inserted in order by a backward scan of the store, one memory read and compare
// per moved entry; a box for an empty store is written directly.
// The pass after the last box tests each kept box for overlap against every later unmarked
// box, one test at a time over the shared multiplier.
// Results leave through a one-deep output register. Reset clears the sequencer, marks,
// counters and valid flag at once; the box memory is not cleared and needs no clearing pass.
`default_nettype none
module greedy_box_suppression_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// Fields from bit 0: box_left, box_top, box_right, box_bottom, box_score, box_class.
	input wire logic [gbs_pkg::TDATA_W-1:0] s_tdata,
	input wire logic s_tlast,
	output logic m_tvalid,
	input wire logic m_tready,
	// Fields from bit 0: kept_left, kept_top, kept_right, kept_bottom, kept_score, kept_class.
	output logic [gbs_pkg::TDATA_W-1:0] m_tdata,
	// Fields from bit 0: overflowed.
	output logic m_tuser,
	output logic m_tlast,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [15:0] cfg_data
);
	import gbs_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_INS_RD = 4'd1;
	localparam logic [3:0] ST_INS_CMP = 4'd2;
	localparam logic [3:0] ST_INS_WR = 4'd3;
	localparam logic [3:0] ST_P_SEL = 4'd4;
	localparam logic [3:0] ST_P_A = 4'd5;
	localparam logic [3:0] ST_P_JSEL = 4'd6;
	localparam logic [3:0] ST_P_B = 4'd7;
	localparam logic [3:0] ST_P_WAIT = 4'd8;
	localparam logic [3:0] ST_P_EMIT = 4'd9;

	logic [3:0] state_q;
	logic [15:0] iou_q;
	logic [6:0] keep_q;
	logic [CNT_W-1:0] count_q;
	logic ovf_q;
	logic [MAX_BOXES-1:0] marks_q;
	box_t nb_q;
	logic last_q;
	box_t a_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [6:0] n_q;
	logic out_valid_q;
	box_t out_box_q;
	logic out_ovf_q;
	logic out_last_q;

	logic mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	box_t mem_wr_data;
	logic [IDX_W-1:0] mem_rd_addr;
	box_t mem_rd_data;
	iou_req_t iou_req;
	iou_rsp_t iou_rsp;
	logic [CNT_W-1:0] j_dec;
	logic [6:0] limit;
	logic any_open;
	logic final_kept;
	logic out_load;
	logic in_acc;

	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(TDATA_W - BOX_W){1'b0}}, out_box_q};
	assign m_tuser = out_ovf_q;
	assign m_tlast = out_last_q;

	assign j_dec = j_q - CNT_W'(1);
	assign limit = (keep_q == 7'd0) ? 7'd1 : keep_q;
	assign out_load = (state_q == ST_P_EMIT) && (!out_valid_q || m_tready);

	always_comb begin
		any_open = 1'b0;
		for (int k = 0; k < MAX_BOXES; k++) begin
			if (CNT_W'(k) < count_q && !marks_q[k]) begin
				any_open = 1'b1;
			end
		end
		final_kept = (7'(n_q + 7'd1) == limit) || !any_open;
	end

	always_comb begin
		mem_wr_en = 1'b0;
		mem_wr_addr = j_q[IDX_W-1:0];
		mem_wr_data = nb_q;
		mem_rd_addr = '0;
		case (state_q)
			ST_INS_RD: mem_rd_addr = j_dec[IDX_W-1:0];
			ST_INS_CMP: begin
				if (mem_rd_data.score < nb_q.score) begin
					mem_wr_en = 1'b1;
					mem_wr_data = mem_rd_data;
				end
			end
			ST_INS_WR: mem_wr_en = 1'b1;
			ST_P_SEL: mem_rd_addr = i_q[IDX_W-1:0];
			ST_P_JSEL: mem_rd_addr = j_q[IDX_W-1:0];
			default: mem_rd_addr = '0;
		endcase
	end

	assign iou_req.start = (state_q == ST_P_B);
	assign iou_req.a = a_q;
	assign iou_req.b = mem_rd_data;

	gbs_box_mem u_mem (
		.clk(clk),
		.wr_en(mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	gbs_iou u_iou (
		.clk(clk),
		.arst_n(arst_n),
		.iou_limit(iou_q),
		.req(iou_req),
		.rsp_q(iou_rsp)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			nb_q <= box_t'(s_tdata[BOX_W-1:0]);
			last_q <= s_tlast;
		end
		if (state_q == ST_P_A) begin
			a_q <= mem_rd_data;
		end
		if (out_load) begin
			out_box_q <= a_q;
			out_ovf_q <= ovf_q;
			out_last_q <= final_kept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iou_q <= IOU_LIMIT_RESET;
			keep_q <= KEEP_LIMIT_RESET;
			count_q <= '0;
			ovf_q <= 1'b0;
			marks_q <= '0;
			i_q <= '0;
			j_q <= '0;
			n_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IOU_LIMIT: iou_q <= cfg_data;
					CFG_KEEP_LIMIT: keep_q <= cfg_data[6:0];
					default: iou_q <= iou_q;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						j_q <= count_q;
						if (count_q == CNT_W'(MAX_BOXES)) begin
							ovf_q <= 1'b1;
							if (s_tlast) begin
								i_q <= '0;
								n_q <= '0;
								state_q <= ST_P_SEL;
							end
						end else if (count_q == '0) begin
							state_q <= ST_INS_WR;
						end else begin
							state_q <= ST_INS_RD;
						end
					end
				end
				ST_INS_RD: state_q <= ST_INS_CMP;
				ST_INS_CMP: begin
					if (mem_rd_data.score < nb_q.score) begin
						j_q <= j_dec;
						state_q <= (j_dec == '0) ? ST_INS_WR : ST_INS_RD;
					end else begin
						state_q <= ST_INS_WR;
					end
				end
				ST_INS_WR: begin
					count_q <= CNT_W'(count_q + CNT_W'(1));
					if (last_q) begin
						i_q <= '0;
						n_q <= '0;
						state_q <= ST_P_SEL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_P_SEL: begin
					if (i_q >= count_q) begin
						marks_q <= '0;
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_IDLE;
					end else if (marks_q[i_q[IDX_W-1:0]]) begin
						i_q <= CNT_W'(i_q + CNT_W'(1));
					end else begin
						state_q <= ST_P_A;
					end
				end
				ST_P_A: begin
					marks_q[i_q[IDX_W-1:0]] <= 1'b1;
					j_q <= CNT_W'(i_q + CNT_W'(1));
					state_q <= ST_P_JSEL;
				end
				ST_P_JSEL: begin
					if (j_q >= count_q) begin
						state_q <= ST_P_EMIT;
					end else if (marks_q[j_q[IDX_W-1:0]]) begin
						j_q <= CNT_W'(j_q + CNT_W'(1));
					end else begin
						state_q <= ST_P_B;
					end
				end
				ST_P_B: state_q <= ST_P_WAIT;
				ST_P_WAIT: begin
					if (iou_rsp.done) begin
						if (iou_rsp.hit) begin
							marks_q[j_q[IDX_W-1:0]] <= 1'b1;
						end
						j_q <= CNT_W'(j_q + CNT_W'(1));
						state_q <= ST_P_JSEL;
					end
				end
				ST_P_EMIT: begin
					if (out_load) begin
						n_q <= 7'(n_q + 7'd1);
						if (final_kept) begin
							marks_q <= '0;
							count_q <= '0;
							ovf_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							i_q <= CNT_W'(i_q + CNT_W'(1));
							state_q <= ST_P_SEL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BOXES))
		else $error("box count above capacity");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == CNT_W'(MAX_BOXES))
		else $error("overflow flagged while store not full");
	a_iou_done: assert property (@(posedge clk) disable iff (!arst_n)
		iou_rsp.done |-> state_q == ST_P_WAIT)
		else $error("overlap result outside of a test");
	a_emit_marked: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> marks_q[i_q[IDX_W-1:0]])
		else $error("emitted box not marked");
`endif
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench of the greedy box suppression block, with a predictor and directed and random sets.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import gbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	typedef enum logic [1:0] {ROW_BOX, ROW_IOU, ROW_KEEP} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		box_t b;
		logic last;
		logic typed;
		box_t kept;
	} row_t;

	typedef struct packed {
		box_t b;
		logic ovf;
		logic lst;
	} kept_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [TDATA_W-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [15:0] cfg_data;

	greedy_box_suppression_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	box_t sorted_boxes[MAX_BOXES];
	bit kill_mark[MAX_BOXES];
	int stored_count;
	bit dropped_any;
	logic [15:0] iou_thresh;
	logic [6:0] keep_max;

	kept_t kept_queue[$];
	int errors;
	int sets_done;
	int results_seen;
	int overflow_sets;
	int idle_cycles;
	bit quiet_mode;

	function automatic longint overlap_area(box_t x);
		longint w;
		longint h;
		w = longint'(x.right) - longint'(x.left);
		h = longint'(x.bottom) - longint'(x.top);
		if (w < 0) w = 0;
		if (h < 0) h = 0;
		return w * h;
	endfunction

	function automatic bit boxes_collide(box_t x, box_t y);
		longint l;
		longint t;
		longint r;
		longint btm;
		longint iw;
		longint ih;
		longint inter;
		longint uni;
		l = (x.left > y.left) ? x.left : y.left;
		t = (x.top > y.top) ? x.top : y.top;
		r = (x.right < y.right) ? x.right : y.right;
		btm = (x.bottom < y.bottom) ? x.bottom : y.bottom;
		iw = r - l + 16;
		ih = btm - t + 16;
		if (iw <= 0 || ih <= 0)
			return 0;
		inter = iw * ih;
		uni = overlap_area(x) + overlap_area(y) - inter;
		if (uni == 0)
			return 1;
		if (uni < 0)
			return 0;
		return inter * 65536 > longint'(iou_thresh) * uni;
	endfunction

	// Inserts one accepted box and, on the final box, queues the kept boxes of the set.
	task automatic suppress_and_queue(box_t b, bit last, bit use_typed, box_t typed_box);
		int pos;
		int n;
		int lim;
		int first_new;
		kept_t k;
		if (stored_count < MAX_BOXES) begin
			pos = 0;
			while (pos < stored_count && sorted_boxes[pos].score >= b.score)
				pos++;
			for (int j = stored_count; j > pos; j--)
				sorted_boxes[j] = sorted_boxes[j - 1];
			sorted_boxes[pos] = b;
			stored_count++;
		end else begin
			dropped_any = 1;
		end
		if (!last)
			return;
		lim = (keep_max == 0) ? 1 : keep_max;
		n = 0;
		first_new = kept_queue.size();
		for (int i = 0; i < stored_count && n < lim; i++) begin
			if (kill_mark[i])
				continue;
			kill_mark[i] = 1;
			for (int j = i + 1; j < stored_count; j++)
				if (!kill_mark[j] && boxes_collide(sorted_boxes[i], sorted_boxes[j]))
					kill_mark[j] = 1;
			k.b = use_typed ? typed_box : sorted_boxes[i];
			k.ovf = dropped_any;
			k.lst = 0;
			kept_queue = {kept_queue, k};
			n++;
		end
		if (n > 0)
			kept_queue[first_new + n - 1].lst = 1;
		if (dropped_any)
			overflow_sets++;
		for (int i = 0; i < MAX_BOXES; i++)
			kill_mark[i] = 0;
		stored_count = 0;
		dropped_any = 0;
		sets_done++;
	endtask

	function automatic int gap_cycles();
		int r;
		if (quiet_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_box(box_t b, bit last, bit use_typed, box_t typed_box);
		int g;
		g = gap_cycles();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, b};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		suppress_and_queue(b, last, use_typed, typed_box);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		s_tvalid <= 1'b0;
		while (kept_queue.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_IOU_LIMIT)
			iou_thresh = value;
		else
			keep_max = value[6:0];
	endtask

	function automatic box_t make_box(logic [15:0] l, logic [15:0] t, logic [15:0] r,
			logic [15:0] btm, logic [15:0] s, logic [9:0] c);
		box_t b;
		b.left = l;
		b.top = t;
		b.right = r;
		b.bottom = btm;
		b.score = s;
		b.cls = c;
		return b;
	endfunction

	function automatic logic [15:0] clip16(int v);
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	// Clustered boxes overlap often; the rest are fully random, inverted edges included.
	function automatic box_t random_box(int cx, int cy);
		int l;
		int t;
		if ($urandom_range(0, 99) < 20)
			return make_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 10'($urandom));
		l = cx + $urandom_range(0, 160);
		t = cy + $urandom_range(0, 160);
		return make_box(clip16(l), clip16(t), clip16(l + $urandom_range(0, 900)),
			clip16(t + $urandom_range(0, 900)), $urandom_range(0, 3) == 0 ?
			16'($urandom_range(0, 3)) : 16'($urandom), 10'($urandom));
	endfunction

	always @(posedge clk) begin
		kept_t e;
		box_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[BOX_W-1:0];
			results_seen++;
			if (kept_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, m_tdata);
			end else begin
				e = kept_queue.pop_front();
				if (got.left !== e.b.left) begin
					errors++;
					$display("%0t: kept_left exp %h got %h", $time, e.b.left, got.left);
				end
				if (got.top !== e.b.top) begin
					errors++;
					$display("%0t: kept_top exp %h got %h", $time, e.b.top, got.top);
				end
				if (got.right !== e.b.right) begin
					errors++;
					$display("%0t: kept_right exp %h got %h", $time, e.b.right, got.right);
				end
				if (got.bottom !== e.b.bottom) begin
					errors++;
					$display("%0t: kept_bottom exp %h got %h", $time, e.b.bottom, got.bottom);
				end
				if (got.score !== e.b.score) begin
					errors++;
					$display("%0t: kept_score exp %h got %h", $time, e.b.score, got.score);
				end
				if (got.cls !== e.b.cls) begin
					errors++;
					$display("%0t: kept_class exp %h got %h", $time, e.b.cls, got.cls);
				end
				if (m_tuser !== e.ovf) begin
					errors++;
					$display("%0t: overflowed exp %b got %b", $time, e.ovf, m_tuser);
				end
				if (m_tlast !== e.lst) begin
					errors++;
					$display("%0t: last_kept exp %b got %b", $time, e.lst, m_tlast);
				end
			end
		end
	end

	int stall_left;
	always @(posedge clk) begin
		logic nxt;
		int r;
		nxt = 1'b1;
		if (stall_left > 0) begin
			stall_left--;
			nxt = 1'b0;
		end else if (!quiet_mode) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				stall_left = $urandom_range(8, 40);
			else if (r < 30)
				nxt = 1'b0;
		end
		m_tready <= nxt;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAIL greedy_box_suppression_top");
			$finish;
		end
	end

	row_t directed[$];
	box_t no_box;

	task automatic add_row(row_kind_t kind, box_t b, bit last, bit typed);
		row_t rw;
		rw.kind = kind;
		rw.b = b;
		rw.last = last;
		rw.typed = typed;
		rw.kept = b;
		directed = {directed, rw};
	endtask

	initial begin
		int set_len;
		int cx;
		int cy;
		int items;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IOU_LIMIT;
		cfg_data = '0;
		sets_done = 0;
		overflow_sets = 0;
		quiet_mode = 0;
		stored_count = 0;
		dropped_any = 0;
		for (int i = 0; i < MAX_BOXES; i++)
			kill_mark[i] = 0;
		iou_thresh = IOU_LIMIT_RESET;
		keep_max = KEEP_LIMIT_RESET;
		no_box = '0;

		// Single-box sets at the field extremes read back unchanged.
		add_row(ROW_BOX, make_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			10'h3FF), 1, 1);
		add_row(ROW_BOX, make_box(0, 0, 0, 0, 0, 0), 1, 1);
		// Identical boxes: the lower score is suppressed.
		add_row(ROW_BOX, make_box(100, 100, 900, 900, 16'h1000, 3), 0, 0);
		add_row(ROW_BOX, make_box(100, 100, 900, 900, 16'h8000, 4), 1, 0);
		// Equal scores on disjoint boxes keep arrival order.
		add_row(ROW_BOX, make_box(0, 0, 100, 100, 16'h4000, 5), 0, 0);
		add_row(ROW_BOX, make_box(5000, 5000, 5100, 5100, 16'h4000, 6), 0, 0);
		add_row(ROW_BOX, make_box(9000, 0, 9100, 100, 16'h4000, 7), 1, 0);
		// Zero union suppresses: a unit-pixel box and a point at its corner.
		add_row(ROW_BOX, make_box(0, 0, 16, 16, 16'h9000, 8), 0, 0);
		add_row(ROW_BOX, make_box(0, 0, 0, 0, 16'h1000, 9), 1, 0);
		// Inverted edges give zero area and an empty intersection.
		add_row(ROW_BOX, make_box(500, 500, 400, 400, 16'hA000, 10), 0, 0);
		add_row(ROW_BOX, make_box(400, 400, 500, 500, 16'h2000, 11), 1, 0);
		// Touching and separated boxes; intersection empty in one axis.
		add_row(ROW_BOX, make_box(0, 0, 100, 100, 16'h3000, 12), 0, 0);
		add_row(ROW_BOX, make_box(116, 0, 200, 100, 16'h2000, 13), 0, 0);
		add_row(ROW_BOX, make_box(0, 117, 100, 200, 16'h1000, 14), 1, 0);
		// Threshold zero and keep limit zero: one box out.
		add_row(ROW_IOU, make_box(0, 0, 0, 0, 0, 0), 0, 0);
		add_row(ROW_KEEP, make_box(0, 0, 0, 0, 0, 0), 0, 0);
		add_row(ROW_BOX, make_box(0, 0, 50, 50, 16'h0100, 15), 0, 0);
		add_row(ROW_BOX, make_box(3000, 3000, 3050, 3050, 16'h0200, 16), 0, 0);
		add_row(ROW_BOX, make_box(6000, 6000, 6050, 6050, 16'h0300, 17), 1, 0);
		// Full threshold and keep limit above capacity.
		add_row(ROW_IOU, make_box(16'hFFFF, 0, 0, 0, 0, 0), 0, 0);
		add_row(ROW_KEEP, make_box(16'h007F, 0, 0, 0, 0, 0), 0, 0);
		add_row(ROW_BOX, make_box(100, 100, 900, 900, 16'h1000, 18), 0, 0);
		add_row(ROW_BOX, make_box(100, 100, 900, 900, 16'h1000, 19), 0, 0);
		add_row(ROW_BOX, make_box(110, 100, 900, 900, 16'h0FFF, 20), 1, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			case (directed[i].kind)
				ROW_IOU: begin
					write_reg(CFG_IOU_LIMIT, directed[i].b.left);
				end
				ROW_KEEP: begin
					write_reg(CFG_KEEP_LIMIT, directed[i].b.left);
				end
				default: begin
					send_box(directed[i].b, directed[i].last, directed[i].typed,
						directed[i].kept);
				end
			endcase
		end

		// One set past capacity exercises the drop flag.
		write_reg(CFG_IOU_LIMIT, IOU_LIMIT_RESET);
		write_reg(CFG_KEEP_LIMIT, 16'd64);
		for (int i = 0; i < MAX_BOXES + 3; i++)
			send_box(random_box(1000, 1000), i == MAX_BOXES + 2, 0, no_box);

		items = 0;
		while (items < 240) begin
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 3))
					0: write_reg(CFG_IOU_LIMIT, 16'($urandom));
					1: write_reg(CFG_IOU_LIMIT, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
					2: write_reg(CFG_KEEP_LIMIT, 16'($urandom_range(0, 8)));
					default: write_reg(CFG_KEEP_LIMIT, $urandom_range(0, 1) ? 16'd64 :
						16'($urandom));
				endcase
			end
			quiet_mode = ($urandom_range(0, 5) == 0);
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 10);
			cx = $urandom_range(0, 64000);
			cy = $urandom_range(0, 64000);
			for (int k = 0; k < set_len; k++)
				send_box(random_box(cx, cy), k == set_len - 1, 0, no_box);
			items += set_len;
		end
		s_tvalid <= 1'b0;
		quiet_mode = 0;

		while (kept_queue.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Ran %0d sets with %0d kept boxes checked, %0d of them past capacity.",
			sets_done, results_seen, overflow_sets);
		if (errors == 0 && kept_queue.size() == 0)
			$display("PASS greedy_box_suppression_top");
		else
			$display("FAIL greedy_box_suppression_top");
		$finish;
	end
endmodule
`default_nettype wire
